FILE: hw/rtl/lcdbp_pkg.sv
// Shared types and constants for the I2C LCD backpack writer.
// Holds the bus phase encoding, queue sizing and the result word layout.
// No dependencies.
package lcdbp_pkg;

	// Queue sizing
	localparam int QUEUE_DEPTH = 64;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Expander byte bits: backlight, enable strobe, register select
	localparam logic [7:0] EXP_BACKLIGHT = 8'h08;
	localparam logic [7:0] EXP_ENABLE    = 8'h04;
	localparam logic [7:0] EXP_RS        = 8'h01;

	// Last bit index inside a byte, last byte index inside a write
	localparam logic [2:0] LAST_BIT  = 3'd7;
	localparam logic [2:0] LAST_BYTE = 3'd4;

	// Request kinds on the input stream
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Bus phases, one delay tick each
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START_A  = 4'd1,
		PH_START_B  = 4'd2,
		PH_BIT_LOW  = 4'd3,
		PH_BIT_HIGH = 4'd4,
		PH_ACK_LOW  = 4'd5,
		PH_ACK_HIGH = 4'd6,
		PH_STOP_A   = 4'd7,
		PH_STOP_B   = 4'd8,
		PH_STOP_C   = 4'd9
	} phase_t;

	// Queue entry: flag above the LCD byte
	typedef struct packed {
		logic       char_flag;
		logic [7:0] value;
	} entry_t;

	// Result word, packed from bit 0 upward: scl_low first
	typedef struct packed {
		logic [2:0] pad;
		logic       ack_seen;
		logic       ack_valid;
		logic       dropped;
		logic [6:0] queue_count;
		logic       busy_res;
		logic       sda_low;
		logic       scl_low;
	} result_t;

endpackage

FILE: hw/rtl/i2c_lcd_backpack_writer.sv
// I2C LCD backpack writer: byte queue in a 64-entry RAM plus an I2C bit-bang
// sequencer. Depends on lcdbp_pkg.
//
// Each result is registered before it shows on the master side. Throughput:
// one request per cycle unless the skid register is full; a two-deep output
// stage keeps intake running while a result waits. The queue RAM is written on
// a push and read on the tick that starts a write, never both in one cycle.
// Reset (arst_n low, asynchronous): empty queue, idle bus, address 39.
module i2c_lcd_backpack_writer (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: device address
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] value, [8] sda_in, [15:9] zero
	input  logic [1:0]  s_tuser,   // [0] operation, [1] char_flag
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] scl_low, [1] sda_low, [2] busy_res,
	                               // [9:3] queue_count, [10] dropped,
	                               // [11] ack_valid, [12] ack_seen, [15:13] zero
);
	import lcdbp_pkg::*;

	// Request fields
	logic       operation;
	logic [7:0] value;
	logic       char_flag;
	logic       sda_in;
	logic       req_acc;

	assign operation = s_tuser[0];
	assign char_flag = s_tuser[1];
	assign value     = s_tdata[7:0];
	assign sda_in    = s_tdata[8];

	// Architectural state
	phase_t            phase_q, phase_n;
	logic [2:0]        bit_pos_q, bit_pos_n;
	logic [2:0]        byte_pos_q, byte_pos_n;
	logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_n;
	logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_n;
	logic [QCNT_W-1:0] count_q, count_n;
	logic [6:0]        dev_addr_q;

	// Queue RAM and its registered read port (the current entry)
	entry_t mem [QUEUE_DEPTH];
	entry_t cur_entry_q;
	logic   mem_we;
	logic   mem_re;

	// Result datapath
	result_t res;
	logic    dropped;
	logic    ack_valid;
	logic    ack_seen;
	logic [7:0] out_byte;
	logic       out_bit;

	// Output stage: main register plus skid register
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    out_take;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign req_acc   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign out_take  = out_valid_q && m_tready;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'd39;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	// Next state: queue bookkeeping and bus sequencer
	always_comb begin
		phase_n    = phase_q;
		bit_pos_n  = bit_pos_q;
		byte_pos_n = byte_pos_q;
		rd_ptr_n   = rd_ptr_q;
		wr_ptr_n   = wr_ptr_q;
		count_n    = count_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		dropped    = 1'b0;
		ack_valid  = 1'b0;
		ack_seen   = 1'b0;
		if (req_acc && operation == OP_PUSH) begin
			// full ring: oldest entry is overwritten, count unchanged
			mem_we   = 1'b1;
			wr_ptr_n = ptr_inc(wr_ptr_q);
			if (count_q == QCNT_W'(QUEUE_DEPTH)) begin
				rd_ptr_n = ptr_inc(rd_ptr_q);
				dropped  = 1'b1;
			end else begin
				count_n = count_q + 1'b1;
			end
		end else if (req_acc) begin
			unique case (phase_q)
				PH_START_A: phase_n = PH_START_B;
				PH_START_B: begin
					bit_pos_n  = '0;
					byte_pos_n = '0;
					phase_n    = PH_BIT_LOW;
				end
				PH_BIT_LOW: phase_n = PH_BIT_HIGH;
				PH_BIT_HIGH: begin
					if (bit_pos_q == LAST_BIT) begin
						phase_n = PH_ACK_LOW;
					end else begin
						bit_pos_n = bit_pos_q + 1'b1;
						phase_n   = PH_BIT_LOW;
					end
				end
				PH_ACK_LOW: begin
					phase_n   = PH_ACK_HIGH;
					ack_valid = 1'b1;
					ack_seen  = !sda_in;
				end
				PH_ACK_HIGH: begin
					if (byte_pos_q >= LAST_BYTE) begin
						phase_n = PH_STOP_A;
					end else begin
						byte_pos_n = byte_pos_q + 1'b1;
						bit_pos_n  = '0;
						phase_n    = PH_BIT_LOW;
					end
				end
				PH_STOP_A: phase_n = PH_STOP_B;
				PH_STOP_B: phase_n = PH_STOP_C;
				default: begin
					// idle, stop C and unused codes: start the next write if any
					if (count_q != '0) begin
						mem_re     = 1'b1;
						rd_ptr_n   = ptr_inc(rd_ptr_q);
						count_n    = count_q - 1'b1;
						bit_pos_n  = '0;
						byte_pos_n = '0;
						phase_n    = PH_START_A;
					end else begin
						phase_n = PH_IDLE;
					end
				end
			endcase
		end
	end

	// Byte on the wire; the entry read at start is only needed from bit phases on
	always_comb begin
		case (byte_pos_n)
			3'd0: out_byte = {dev_addr_q, 1'b0};
			3'd1: out_byte = {cur_entry_q.value[7:4], 4'h0} | EXP_BACKLIGHT | EXP_ENABLE
				| (cur_entry_q.char_flag ? EXP_RS : 8'h00);
			3'd2: out_byte = {cur_entry_q.value[7:4], 4'h0} | EXP_BACKLIGHT
				| (cur_entry_q.char_flag ? EXP_RS : 8'h00);
			3'd3: out_byte = {cur_entry_q.value[3:0], 4'h0} | EXP_BACKLIGHT | EXP_ENABLE
				| (cur_entry_q.char_flag ? EXP_RS : 8'h00);
			default: out_byte = {cur_entry_q.value[3:0], 4'h0} | EXP_BACKLIGHT
				| (cur_entry_q.char_flag ? EXP_RS : 8'h00);
		endcase
		// MSB first: bit index 7 - pos
		out_bit = out_byte[~bit_pos_n];
	end

	// Line levels of the phase after this request
	always_comb begin
		res             = '0;
		res.dropped     = dropped;
		res.ack_valid   = ack_valid;
		res.ack_seen    = ack_seen;
		res.queue_count = 7'(count_n);
		res.busy_res    = (phase_n >= PH_START_A) && (phase_n <= PH_STOP_C);
		case (phase_n)
			PH_START_B: res.sda_low = 1'b1;
			PH_BIT_LOW: begin
				res.scl_low = 1'b1;
				res.sda_low = !out_bit;
			end
			PH_BIT_HIGH: res.sda_low = !out_bit;
			PH_ACK_LOW:  res.scl_low = 1'b1;
			PH_STOP_A: begin
				res.scl_low = 1'b1;
				res.sda_low = 1'b1;
			end
			PH_STOP_B: res.sda_low = 1'b1;
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_pos_q  <= '0;
			byte_pos_q <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			count_q    <= '0;
		end else begin
			phase_q    <= phase_n;
			bit_pos_q  <= bit_pos_n;
			byte_pos_q <= byte_pos_n;
			rd_ptr_q   <= rd_ptr_n;
			wr_ptr_q   <= wr_ptr_n;
			count_q    <= count_n;
		end
	end

	// Queue RAM: one write or one read per cycle, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= '{char_flag: char_flag, value: value};
		end
		if (mem_re) begin
			cur_entry_q <= mem[rd_ptr_q];
		end
	end

	// Output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (req_acc) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule
